// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mipmap chain blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication, checked on every rising clock edge.
`define BFMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BFMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bfmc_pkg.sv
// ---------------------------------------------------------------------------
// bfmc_pkg
// Types, constants and helper functions for the box filter mipmap chain.
// ---------------------------------------------------------------------------
package bfmc_pkg;

	localparam int MAX_WIDTH_DEF    = 4096;
	localparam int MAX_HEIGHT_DEF   = 4096;
	localparam int MAX_LEVELS_DEF   = 12;
	localparam int MAX_CHANNELS_DEF = 4;

	localparam int LANES      = 4;
	localparam int CHAN_W     = 8;
	localparam int PAIR_W     = CHAN_W + 1;
	localparam int LEVEL_W    = 4;
	localparam int SLICE_W    = 8;
	localparam int COORD_W    = 11;
	localparam int DIM_REG_W  = 13;
	localparam int SCNT_REG_W = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int IN_DATA_W  = LANES * CHAN_W;
	localparam int OUT_DATA_W = 72;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_CHANNELS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT   = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_SUM
	} bfmc_state_t;

	// Start of the pair-sum line of target level t inside the shared line memory.
	function automatic int line_base(input int t, input int mw);
		int base;
		int n;
		base = 0;
		for (int k = 1; k < 31; k++) begin
			if (k < t) begin
				n = mw >> k;
				base = base + ((n < 1) ? 1 : n);
			end
		end
		return base;
	endfunction

endpackage

// File: design/box_filter_mipmap_chain_unit.sv
// ---------------------------------------------------------------------------
// box_filter_mipmap_chain_unit
// Streaming 2x2 box filter mip chain with four channel lanes and a line memory.
// ---------------------------------------------------------------------------
// A pixel is accepted in the idle state and its level 0 step is done in the step state,
// so a pixel that completes no 2x2 block holds the input through those two states.
// Each level it completes adds a step state to step the counters and access the
// line memory, and a sum state for the registered read and the lane sums, which waits
// while the output register is full. The sum state registers each result for output.
// Reset sets 1x1, four channels, one slice, clears the counters; line memory is undefined.
`include "assert_macros.svh"
module box_filter_mipmap_chain_unit #(
	parameter int MAX_WIDTH    = bfmc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = bfmc_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_LEVELS   = bfmc_pkg::MAX_LEVELS_DEF,
	parameter int MAX_CHANNELS = bfmc_pkg::MAX_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// chan_0, chan_1, chan_2, chan_3
	input  logic [bfmc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// level, slice, px, py, out_0, out_1, out_2, out_3, zero fill
	output logic [bfmc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bfmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bfmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW = (MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);
	localparam int DW = CW + 1;
	localparam int SW = $clog2(MAX_LEVELS + 1);
	localparam int LINE_SLOTS = MAX_WIDTH + MAX_LEVELS + 1;
	localparam int AW = $clog2(LINE_SLOTS);
	localparam int MW = bfmc_pkg::LANES * bfmc_pkg::PAIR_W;
	localparam int LANES = bfmc_pkg::LANES;
	localparam int CHW = bfmc_pkg::CHAN_W;
	localparam int PW = bfmc_pkg::PAIR_W;

	bfmc_pkg::bfmc_state_t state_q, state_nx;

	logic [bfmc_pkg::DIM_REG_W-1:0]  img_w_q, img_h_q;
	logic                            four_q;
	logic [bfmc_pkg::SCNT_REG_W-1:0] scnt_q;
	logic [bfmc_pkg::SLICE_W-1:0]    slice_q, cur_slice_q;

	logic [CW-1:0] col_q [MAX_LEVELS+1];
	logic [CW-1:0] row_q [MAX_LEVELS+1];

	logic [SW-1:0]  s_q;
	logic [DW-1:0]  w_q, h_q;
	logic [CHW-1:0] v_q [LANES];
	logic [CW-1:0]  x_q, y_q;
	logic           h_one_q;

	logic [DW-1:0] w_clamp, h_clamp;
	logic [8:0]    slices;
	logic          cfg_hit, in_acc;

	logic [CW-1:0] c, r;
	logic [DW:0]   c_nx, r_nx;
	logic          wrap_c, wrap_r;
	logic          w_one, h_one, stop;
	logic          horiz_pass, vert_pass;
	logic          do_step, go_sum, left_we, mem_we, mem_re;
	logic [SW-1:0] t;
	logic [CW-1:0] x_nx, y_nx;
	logic [AW-1:0] base_tab [MAX_LEVELS+1];
	logic [AW-1:0] idx;

	logic [PW-1:0]  pair [LANES];
	logic [CHW-1:0] avg [LANES];
	logic [MW-1:0]  wr_data, rd_data;

	logic          out_free, emit;
	logic          last_nx;
	logic [DW-1:0] tw, th;
	logic [CW-1:0] c2, r2;
	logic          out_valid_q, out_last_q;
	logic          out_level_ok;
	logic [bfmc_pkg::OUT_DATA_W-1:0] out_data_q;
	logic [bfmc_pkg::OUT_DATA_W-1:0] out_data_nx;

	for (genvar k = 0; k <= MAX_LEVELS; k++) begin : g_base
		assign base_tab[k] = AW'(bfmc_pkg::line_base(k, MAX_WIDTH));
	end

	always_comb begin
		if (img_w_q == '0) begin
			w_clamp = DW'(1);
		end else if (32'(img_w_q) > MAX_WIDTH) begin
			w_clamp = DW'(MAX_WIDTH);
		end else begin
			w_clamp = DW'(img_w_q);
		end
		if (img_h_q == '0) begin
			h_clamp = DW'(1);
		end else if (32'(img_h_q) > MAX_HEIGHT) begin
			h_clamp = DW'(MAX_HEIGHT);
		end else begin
			h_clamp = DW'(img_h_q);
		end
		if (scnt_q == '0) begin
			slices = 9'd1;
		end else if (scnt_q > 9'd256) begin
			slices = 9'd256;
		end else begin
			slices = scnt_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg_hit = cfg_valid && (cfg_index == bfmc_pkg::CFG_IMAGE_WIDTH ||
		cfg_index == bfmc_pkg::CFG_IMAGE_HEIGHT || cfg_index == bfmc_pkg::CFG_FOUR_CHANNELS ||
		cfg_index == bfmc_pkg::CFG_SLICE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= bfmc_pkg::DIM_REG_W'(1);
			img_h_q <= bfmc_pkg::DIM_REG_W'(1);
			four_q  <= 1'b1;
			scnt_q  <= bfmc_pkg::SCNT_REG_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bfmc_pkg::CFG_IMAGE_WIDTH:   img_w_q <= cfg_data;
				bfmc_pkg::CFG_IMAGE_HEIGHT:  img_h_q <= cfg_data;
				bfmc_pkg::CFG_FOUR_CHANNELS: four_q <= cfg_data[0];
				bfmc_pkg::CFG_SLICE_COUNT:   scnt_q <= cfg_data[bfmc_pkg::SCNT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Level step: counters of level s and the two pass tests.
	assign c = col_q[s_q];
	assign r = row_q[s_q];
	assign c_nx = (DW+1)'(c) + (DW+1)'(1);
	assign r_nx = (DW+1)'(r) + (DW+1)'(1);
	assign wrap_c = c_nx >= {1'b0, w_q};
	assign wrap_r = wrap_c && (r_nx >= {1'b0, h_q});
	assign w_one = w_q == DW'(1);
	assign h_one = h_q == DW'(1);
	assign stop = w_one && h_one;
	assign horiz_pass = w_one || c[0];
	assign vert_pass = h_one || r[0];
	assign t = s_q + SW'(1);
	assign x_nx = w_one ? c : (c >> 1);
	assign y_nx = h_one ? r : (r >> 1);
	assign idx = base_tab[t] + AW'(x_nx);

	assign tw = ((w_q >> 1) == '0) ? DW'(1) : (w_q >> 1);
	assign th = ((h_q >> 1) == '0) ? DW'(1) : (h_q >> 1);
	assign c2 = col_q[t];
	assign r2 = row_q[t];

	always_comb begin
		if (32'(t) >= MAX_LEVELS) begin
			last_nx = 1'b1;
		end else begin
			last_nx = !(!((tw == DW'(1)) && (th == DW'(1))) &&
				((tw == DW'(1)) || c2[0]) && ((th == DW'(1)) || r2[0]));
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bfmc_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_nx = bfmc_pkg::ST_STEP;
				end
			end
			bfmc_pkg::ST_STEP: begin
				state_nx = go_sum ? bfmc_pkg::ST_SUM : bfmc_pkg::ST_IDLE;
			end
			bfmc_pkg::ST_SUM: begin
				if (out_free) begin
					state_nx = (32'(t) >= MAX_LEVELS) ? bfmc_pkg::ST_IDLE : bfmc_pkg::ST_STEP;
				end
			end
			default: state_nx = bfmc_pkg::ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		do_step = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			bfmc_pkg::ST_IDLE: s_axis_tready = 1'b1;
			bfmc_pkg::ST_STEP: do_step = 1'b1;
			bfmc_pkg::ST_SUM:  emit = out_free;
			default: ;
		endcase
	end

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign go_sum = do_step && !stop && horiz_pass && vert_pass;
	assign left_we = do_step && !stop && !w_one && !c[0] && !wrap_c;
	assign mem_we = do_step && !stop && horiz_pass && !h_one && !r[0] && !(r_nx >= {1'b0, h_q});
	assign mem_re = go_sum && !h_one;
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfmc_pkg::ST_IDLE;
			slice_q <= '0;
			for (int i = 0; i <= MAX_LEVELS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (cfg_hit) begin
				slice_q <= '0;
				for (int i = 0; i <= MAX_LEVELS; i++) begin
					col_q[i] <= '0;
					row_q[i] <= '0;
				end
			end else if (do_step) begin
				col_q[s_q] <= wrap_c ? '0 : CW'(c_nx);
				if (wrap_c) begin
					row_q[s_q] <= wrap_r ? '0 : CW'(r_nx);
				end
				if (wrap_r && s_q == '0) begin
					slice_q <= ((9'(slice_q) + 9'd1) >= slices) ? '0 : slice_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_q <= '0;
			w_q <= w_clamp;
			h_q <= h_clamp;
			cur_slice_q <= slice_q;
			for (int l = 0; l < LANES; l++) begin
				v_q[l] <= (l < MAX_CHANNELS && (l == 0 || four_q)) ?
					s_axis_tdata[l*CHW +: CHW] : '0;
			end
		end else if (emit) begin
			s_q <= t;
			w_q <= tw;
			h_q <= th;
			for (int l = 0; l < LANES; l++) begin
				v_q[l] <= avg[l];
			end
		end
		if (go_sum) begin
			x_q <= x_nx;
			y_q <= y_nx;
			h_one_q <= h_one;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		bfmc_lane #(
			.MAX_LEVELS(MAX_LEVELS),
			.SW(SW)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (cfg_hit),
			.left_we(left_we),
			.lvl    (t),
			.pix    (v_q[l]),
			.w_one  (w_one),
			.pair_en(go_sum),
			.h_one  (h_one_q),
			.above  (rd_data[l*PW +: PW]),
			.pair   (pair[l]),
			.avg    (avg[l])
		);
		assign wr_data[l*PW +: PW] = pair[l];
	end

	bfmc_line_mem #(
		.DEPTH(LINE_SLOTS),
		.AW(AW),
		.DW(MW)
	) u_line_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(idx),
		.wr_data(wr_data),
		.rd_en  (mem_re),
		.rd_addr(idx),
		.rd_data(rd_data)
	);

	// Merge the lane averages with the level, slice and position into one output word.
	always_comb begin
		out_data_nx = '0;
		out_data_nx[3:0]   = bfmc_pkg::LEVEL_W'(t);
		out_data_nx[11:4]  = cur_slice_q;
		out_data_nx[22:12] = bfmc_pkg::COORD_W'(x_q);
		out_data_nx[33:23] = bfmc_pkg::COORD_W'(y_q);
		for (int l = 0; l < LANES; l++) begin
			out_data_nx[34 + l*CHW +: CHW] = avg[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= out_data_nx;
			out_last_q <= last_nx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

	assign out_level_ok = (out_data_q[3:0] != 4'd0) && (32'(out_data_q[3:0]) <= MAX_LEVELS);

	`BFMC_ASSERT_SAME(a_mem_port_excl, clk, arst_n, mem_we, !mem_re, "line memory conflict")
	`BFMC_ASSERT_NEXT(a_accept_steps, clk, arst_n, in_acc, state_q == bfmc_pkg::ST_STEP, "no step")
	`BFMC_ASSERT_SAME(a_level_range, clk, arst_n, m_axis_tvalid, out_level_ok, "bad output level")

endmodule

// File: design/bfmc_line_mem.sv
// ---------------------------------------------------------------------------
// bfmc_line_mem
// Single write port, single registered read port line memory for pair sums.
// ---------------------------------------------------------------------------
module bfmc_line_mem #(
	parameter int DEPTH = 4109,
	parameter int AW    = 13,
	parameter int DW    = 36
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/bfmc_lane.sv
// ---------------------------------------------------------------------------
// bfmc_lane
// One channel of the 2x2 box filter: horizontal pair, vertical sum, average.
// ---------------------------------------------------------------------------
module bfmc_lane #(
	parameter int MAX_LEVELS = 12,
	parameter int SW         = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          left_we,
	input  logic [SW-1:0]                 lvl,
	input  logic [bfmc_pkg::CHAN_W-1:0]   pix,
	input  logic                          w_one,
	input  logic                          pair_en,
	input  logic                          h_one,
	input  logic [bfmc_pkg::PAIR_W-1:0]   above,
	output logic [bfmc_pkg::PAIR_W-1:0]   pair,
	output logic [bfmc_pkg::CHAN_W-1:0]   avg
);

	logic [bfmc_pkg::CHAN_W-1:0] left_q [MAX_LEVELS+1];
	logic [bfmc_pkg::PAIR_W-1:0] pair_s1;
	logic [bfmc_pkg::PAIR_W:0]   sum;

	always_comb begin
		if (w_one) begin
			pair = {pix, 1'b0};
		end else begin
			pair = bfmc_pkg::PAIR_W'(left_q[lvl]) + bfmc_pkg::PAIR_W'(pix);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= MAX_LEVELS; i++) begin
				left_q[i] <= '0;
			end
		end else if (clear) begin
			for (int i = 0; i <= MAX_LEVELS; i++) begin
				left_q[i] <= '0;
			end
		end else if (left_we) begin
			left_q[lvl] <= pix;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_en) begin
			pair_s1 <= pair;
		end
	end

	always_comb begin
		if (h_one) begin
			sum = {pair_s1, 1'b0};
		end else begin
			sum = (bfmc_pkg::PAIR_W+1)'(above) + (bfmc_pkg::PAIR_W+1)'(pair_s1);
		end
	end

	assign avg = sum[bfmc_pkg::PAIR_W:2];

endmodule
